// ===== rtl/core/cso_pkg.sv =====
// Shared types and constants for the cursor sprite overlay unit.
// Holds opcode and fill codes, colors, the arrow bitmap and the queue entry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cso_pkg;

   localparam int FIELD_BITS = 13;
   localparam int COLOR_BITS = 32;
   localparam int ARROW_ROWS = 18;
   localparam int ARROW_COLS = 12;
   localparam int ARM_REACH  = 3;

   localparam logic [COLOR_BITS-1:0] COLOR_WHITE  = 32'hFFFF_FFFF;
   localparam logic [COLOR_BITS-1:0] COLOR_LEFT   = 32'hFFFF_E3E3;
   localparam logic [COLOR_BITS-1:0] COLOR_MIDDLE = 32'hFFE3_FFE3;
   localparam logic [COLOR_BITS-1:0] COLOR_RIGHT  = 32'hFFE3_E3FF;
   localparam logic [COLOR_BITS-1:0] COLOR_BLACK  = 32'hFF00_0000;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_QUERY  = 1'b1
   } opcode_type;

   typedef enum logic {
      STYLE_CROSSHAIR = 1'b0,
      STYLE_ARROW     = 1'b1
   } style_type;

   typedef enum logic [1:0] {
      FILL_WHITE  = 2'd0,
      FILL_LEFT   = 2'd1,
      FILL_MIDDLE = 2'd2,
      FILL_RIGHT  = 2'd3
   } fill_type;

   typedef enum logic [1:0] {
      CSR_STYLE  = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   localparam logic [FIELD_BITS-1:0] WIDTH_RESET  = 13'd1024;
   localparam logic [FIELD_BITS-1:0] HEIGHT_RESET = 13'd768;

   typedef enum logic [1:0] {
      PIX_CLEAR    = 2'd0,
      PIX_BORDER   = 2'd1,
      PIX_INTERIOR = 2'd2
   } pix_type;

   localparam logic [1:0] ARROW_MAP [ARROW_ROWS][ARROW_COLS] = '{
      '{2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0},
      '{2'd1,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0},
      '{2'd1,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0},
      '{2'd1,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0},
      '{2'd1,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0},
      '{2'd1,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0},
      '{2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0,2'd0},
      '{2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0},
      '{2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0},
      '{2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0},
      '{2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd1,2'd1,2'd0,2'd0},
      '{2'd1,2'd2,2'd2,2'd1,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0,2'd0},
      '{2'd1,2'd2,2'd1,2'd0,2'd1,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0},
      '{2'd1,2'd1,2'd0,2'd0,2'd1,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0,2'd0},
      '{2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0},
      '{2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd2,2'd1,2'd0,2'd0},
      '{2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd2,2'd1,2'd0,2'd0},
      '{2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd1,2'd1,2'd1,2'd0,2'd0,2'd0}
   };

   // One classified transaction as it waits for the back end.
   typedef struct packed {
      logic                    is_update;
      logic                    on_screen;
      logic [FIELD_BITS-1:0]   pos_x;
      logic [FIELD_BITS-1:0]   pos_y;
      fill_type                fill;
      logic [COLOR_BITS-1:0]   background;
   } entry_type;

   function automatic logic [COLOR_BITS-1:0] fill_color(input fill_type sel);
      logic [COLOR_BITS-1:0] c;
      unique case (sel)
         FILL_LEFT:   c = COLOR_LEFT;
         FILL_MIDDLE: c = COLOR_MIDDLE;
         FILL_RIGHT:  c = COLOR_RIGHT;
         default:     c = COLOR_WHITE;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cso_front.sv =====
// Front end: classifies each input transaction and prepares a queue entry.
// Clamps update positions, picks the fill code and checks query bounds.
// Depends on cso_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cso_front #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                           req_opcode,
   input  wire logic signed [cso_pkg::FIELD_BITS-1:0] req_coord_x,
   input  wire logic signed [cso_pkg::FIELD_BITS-1:0] req_coord_y,
   input  wire logic [2:0]                     req_buttons,
   input  wire logic [cso_pkg::COLOR_BITS-1:0] req_background,
   input  wire logic [cso_pkg::FIELD_BITS-1:0] screen_width,
   input  wire logic [cso_pkg::FIELD_BITS-1:0] screen_height,
   output cso_pkg::entry_type                  entry
);
   import cso_pkg::*;

   localparam int EW = (COORD_BITS + 1 > FIELD_BITS) ? COORD_BITS + 1 : FIELD_BITS;
   localparam logic [EW-1:0] LIMIT = EW'(1) << COORD_BITS;

   logic [EW-1:0] eff_w;
   logic [EW-1:0] eff_h;
   logic [EW-1:0] ext_x;
   logic [EW-1:0] ext_y;
   logic          x_inside;
   logic          y_inside;
   logic [EW-1:0] clamp_x;
   logic [EW-1:0] clamp_y;

   function automatic logic [EW-1:0] eff_size(input logic [FIELD_BITS-1:0] reg_val);
      logic [EW-1:0] r;
      r = EW'(reg_val);
      if (r == '0) begin
         r = EW'(1);
      end else if (r > LIMIT) begin
         r = LIMIT;
      end
      return r;
   endfunction

   always_comb begin
      eff_w    = eff_size(screen_width);
      eff_h    = eff_size(screen_height);
      ext_x    = EW'(req_coord_x[FIELD_BITS-2:0]);
      ext_y    = EW'(req_coord_y[FIELD_BITS-2:0]);
      x_inside = !req_coord_x[FIELD_BITS-1] && (ext_x < eff_w);
      y_inside = !req_coord_y[FIELD_BITS-1] && (ext_y < eff_h);

      if (req_coord_x[FIELD_BITS-1]) begin
         clamp_x = '0;
      end else if (!x_inside) begin
         clamp_x = eff_w - EW'(1);
      end else begin
         clamp_x = ext_x;
      end
      if (req_coord_y[FIELD_BITS-1]) begin
         clamp_y = '0;
      end else if (!y_inside) begin
         clamp_y = eff_h - EW'(1);
      end else begin
         clamp_y = ext_y;
      end

      entry.is_update  = (req_opcode == OP_UPDATE);
      entry.on_screen  = x_inside && y_inside;
      entry.background = req_background;
      if (req_opcode == OP_UPDATE) begin
         entry.pos_x = clamp_x[FIELD_BITS-1:0];
         entry.pos_y = clamp_y[FIELD_BITS-1:0];
      end else begin
         entry.pos_x = req_coord_x;
         entry.pos_y = req_coord_y;
      end

      if (req_buttons[0]) begin
         entry.fill = FILL_LEFT;
      end else if (req_buttons[2]) begin
         entry.fill = FILL_MIDDLE;
      end else if (req_buttons[1]) begin
         entry.fill = FILL_RIGHT;
      end else begin
         entry.fill = FILL_WHITE;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cso_queue.sv =====
// Small FIFO of classified entries between the front and back ends.
// Registered storage with head read; reports its fill state as empty, full and count.
// Depends on cso_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cso_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  cso_pkg::entry_type      push_entry,
   input  wire logic               pop,
   output cso_pkg::entry_type      head,
   output logic                    empty,
   output logic                    full,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import cso_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         slots_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      logic [PW-1:0] n;
      n = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
      return n;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head  = slots_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(DEPTH));
   assign count = count_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cso_back.sv =====
// Back end: holds the cursor state, composites query pixels, drives the result.
// Applies updates in order with queries; the result sits in an output register.
// Depends on cso_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cso_back #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  cso_pkg::entry_type                  head,
   input  wire logic                           head_valid,
   input  wire logic                           cursor_style,
   output logic                                pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [cso_pkg::COLOR_BITS-1:0]      rsp_pixel_color,
   output logic                                rsp_cursor_hit
);
   import cso_pkg::*;

   localparam int DW = ((COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS) + 2;

   logic [COORD_BITS-1:0]   col_ff;
   logic [COORD_BITS-1:0]   row_ff;
   fill_type                fill_ff;
   logic                    valid_ff, valid_in;
   logic [COLOR_BITS-1:0]   color_ff, color_in;
   logic                    hit_ff, hit_in;
   logic signed [DW-1:0]    dx;
   logic signed [DW-1:0]    dy;
   logic [1:0]              pix;

   always_comb begin
      pop      = head_valid && (head.is_update || !valid_ff || rsp_ready);
      dx       = DW'(head.pos_x) - DW'(col_ff);
      dy       = DW'(head.pos_y) - DW'(row_ff);
      pix      = PIX_CLEAR;
      hit_in   = 1'b0;
      color_in = head.background;

      if (head.on_screen) begin
         if (cursor_style == STYLE_CROSSHAIR) begin
            if (((dy == 0) && (dx >= -ARM_REACH) && (dx <= ARM_REACH)) ||
                ((dx == 0) && (dy >= -ARM_REACH) && (dy <= ARM_REACH))) begin
               hit_in   = 1'b1;
               color_in = ((dx == 0) && (dy == 0)) ? fill_color(fill_ff) : COLOR_WHITE;
            end
         end else if ((dx >= 0) && (dx < ARROW_COLS) && (dy >= 0) && (dy < ARROW_ROWS)) begin
            pix = ARROW_MAP[dy[4:0]][dx[3:0]];
            if (pix != PIX_CLEAR) begin
               hit_in   = 1'b1;
               color_in = (pix == PIX_BORDER) ? COLOR_BLACK : fill_color(fill_ff);
            end
         end
      end

      valid_in = valid_ff && !rsp_ready;
      if (pop && !head.is_update) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         fill_ff  <= FILL_WHITE;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop && head.is_update) begin
            col_ff  <= COORD_BITS'(head.pos_x);
            row_ff  <= COORD_BITS'(head.pos_y);
            fill_ff <= head.fill;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && !head.is_update) begin
         color_ff <= color_in;
         hit_ff   <= hit_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_cursor_hit  = hit_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cursor_sprite_overlay_unit.sv =====
// Top level of the hardware cursor overlay: configuration registers,
// front end, entry queue and back end. Depends on cso_pkg, cso_front,
// cso_queue and cso_back.
//
//   Channel   Direction  Handshake           Carries
//   req_      in         req_valid/ready     opcode, coord_x/y, buttons, background
//   rsp_      out        rsp_valid/ready     pixel_color, cursor_hit
//   csr_      in         csr_write_enable    index, 13-bit write data
//
// One transaction enters per cycle while the queue is not full; a query result is
// registered in the back end after the entry queue; updates produce no result.
// Throughput is set by the back end; it retires one entry per cycle unless stalled.
// A stalled result port holds the output register while the queue absorbs
// up to QUEUE_DEPTH more transactions; req_ready drops only when it is full.
// Reset restores the configuration defaults and clears the cursor state.
`timescale 1ns / 1ps
`default_nettype none

module cursor_sprite_overlay_unit #(
   parameter int COORD_BITS  = 12,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_opcode,
   input  wire logic signed [cso_pkg::FIELD_BITS-1:0] req_coord_x,
   input  wire logic signed [cso_pkg::FIELD_BITS-1:0] req_coord_y,
   input  wire logic [2:0]                     req_buttons,
   input  wire logic [cso_pkg::COLOR_BITS-1:0] req_background,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [cso_pkg::COLOR_BITS-1:0]      rsp_pixel_color,
   output logic                                rsp_cursor_hit,
   input  wire logic                           csr_write_enable,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [cso_pkg::FIELD_BITS-1:0] csr_write_data
);
   import cso_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic                    style_ff;
   logic [FIELD_BITS-1:0]   width_ff;
   logic [FIELD_BITS-1:0]   height_ff;
   entry_type               new_entry;
   entry_type               head;
   logic                    q_empty;
   logic                    q_full;
   logic [CW-1:0]           q_count;
   logic                    push;
   logic                    pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff  <= STYLE_ARROW;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_STYLE:  style_ff  <= csr_write_data[0];
            CSR_WIDTH:  width_ff  <= csr_write_data;
            CSR_HEIGHT: height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   cso_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .req_opcode     (req_opcode),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_buttons    (req_buttons),
      .req_background (req_background),
      .screen_width   (width_ff),
      .screen_height  (height_ff),
      .entry          (new_entry)
   );

   cso_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (new_entry),
      .pop        (pop),
      .head       (head),
      .empty      (q_empty),
      .full       (q_full),
      .count      (q_count)
   );

   cso_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_valid      (!q_empty),
      .cursor_style    (style_ff),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_cursor_hit  (rsp_cursor_hit)
   );

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CW'(QUEUE_DEPTH))
      else $error("entry queue holds more than its depth");

   a_queue_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (q_count == $past(q_count) + CW'(1)))
      else $error("entry queue did not grow on a lone push");

   a_hit_color: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cursor_hit) |->
         (rsp_pixel_color == COLOR_WHITE || rsp_pixel_color == COLOR_BLACK ||
          rsp_pixel_color == COLOR_LEFT || rsp_pixel_color == COLOR_MIDDLE ||
          rsp_pixel_color == COLOR_RIGHT))
      else $error("covered pixel carries a color outside the cursor palette");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("back end retired an entry from an empty queue");
`endif

endmodule

`default_nettype wire
